// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/sstf_pkg.sv -----
// Package with the types, widths and helper function of the SSTF scheduler.
package sstf_pkg;

  localparam int unsigned CYL_W = 16;
  localparam int unsigned SUM_W = 22;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  function automatic logic [CYL_W-1:0] abs_diff(input logic [CYL_W-1:0] a,
                                                input logic [CYL_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- design/sstf_in_if.sv -----
// Input channel of the scheduler: one load or run transaction.
interface sstf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sstf_pkg::CYL_W-1:0]  position;

  modport source (output valid, output action, output position, input ready);
  modport sink   (input valid, input action, input position, output ready);
endinterface

// ----- design/sstf_out_if.sv -----
// Output channel of the scheduler: one served cylinder per transaction.
interface sstf_out_if;
  logic                        valid;
  logic                        ready;
  logic [sstf_pkg::CYL_W-1:0]  cylinder;
  logic [sstf_pkg::SUM_W-1:0]  total_movement;
  logic                        empty_run;
  logic                        dropped;
  logic                        last;

  modport source (output valid, output cylinder, output total_movement, output empty_run,
                  output dropped, output last, input ready);
  modport sink   (input valid, input cylinder, input total_movement, input empty_run,
                  input dropped, input last, output ready);
endinterface

// ----- design/sstf_ram.sv -----
// Simple dual-port request memory with one write port and a registered read port.
module sstf_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 17,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/sstf_disk_scheduler_core.sv -----
// Top level of the shortest-seek-time-first disk scheduler.
// A load goes straight into the request memory, or is dropped and flagged when full.
// For each result, a run reads all N loaded requests, served ones included, through
// the read port in S_SCAN, then S_DRAIN and S_DECIDE, which waits for a free output.
// An empty run produces its single result in the cycle after it is accepted.
// Reset clears the request count, the dropped flag and the control state; the memory is not.
module sstf_disk_scheduler_core #(
  parameter int unsigned MAX_REQUESTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sstf_in_if.sink           in_i,
  sstf_out_if.source        out_o
);

  localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned CY = sstf_pkg::CYL_W;
  localparam int unsigned SW = sstf_pkg::SUM_W;
  localparam int unsigned DW = CY + 1;

  sstf_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] served_q, served_d;
  logic          dropped_q, dropped_d;
  logic [CY-1:0] head_q, head_d;
  logic [CY-1:0] split_q, split_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          rd_valid_q, rd_valid_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic          lo_found_q, lo_found_d;
  logic [CY-1:0] lo_val_q, lo_val_d;
  logic [AW-1:0] lo_idx_q, lo_idx_d;
  logic          hi_found_q, hi_found_d;
  logic [CY-1:0] hi_val_q, hi_val_d;
  logic [AW-1:0] hi_idx_q, hi_idx_d;

  logic          out_valid_q, out_valid_d;
  logic [CY-1:0] out_cyl_q, out_cyl_d;
  logic [SW-1:0] out_sum_q, out_sum_d;
  logic          out_empty_q, out_empty_d;
  logic          out_drop_q, out_drop_d;
  logic          out_last_q, out_last_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] mem_rdata;

  logic          in_acc;
  logic          out_free;
  logic          has_room;
  logic [CY-1:0] rd_val;
  logic          rd_served;
  logic [CY-1:0] dist_lo;
  logic [CY-1:0] dist_hi;
  logic          take_lo;
  logic [CY-1:0] pick_val;
  logic [AW-1:0] pick_idx;
  logic [CY-1:0] pick_dist;
  logic [SW-1:0] pick_sum;
  logic          pick_last;

  sstf_ram #(
    .DEPTH (MAX_REQUESTS),
    .WIDTH (DW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == sstf_pkg::S_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign has_room   = count_q < CW'(MAX_REQUESTS);

  assign rd_val    = mem_rdata[CY-1:0];
  assign rd_served = mem_rdata[CY];

  assign dist_lo   = sstf_pkg::abs_diff(head_q, lo_val_q);
  assign dist_hi   = sstf_pkg::abs_diff(head_q, hi_val_q);
  assign take_lo   = lo_found_q && (!hi_found_q || (dist_lo < dist_hi));
  assign pick_val  = take_lo ? lo_val_q : hi_val_q;
  assign pick_idx  = take_lo ? lo_idx_q : hi_idx_q;
  assign pick_dist = take_lo ? dist_lo : dist_hi;
  assign pick_sum  = sum_q + SW'(pick_dist);
  assign pick_last = (served_q + CW'(1)) == count_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = {1'b0, in_i.position};
    if (state_q == sstf_pkg::S_DECIDE) begin
      mem_we    = out_free;
      mem_waddr = pick_idx;
      mem_wdata = {1'b1, pick_val};
    end else if (in_acc && (in_i.action == sstf_pkg::ACT_LOAD) && has_room) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    served_d    = served_q;
    dropped_d   = dropped_q;
    head_d      = head_q;
    split_d     = split_q;
    sum_d       = sum_q;
    addr_d      = addr_q;
    rd_valid_d  = (state_q == sstf_pkg::S_SCAN);
    rd_idx_d    = addr_q;
    lo_found_d  = lo_found_q;
    lo_val_d    = lo_val_q;
    lo_idx_d    = lo_idx_q;
    hi_found_d  = hi_found_q;
    hi_val_d    = hi_val_q;
    hi_idx_d    = hi_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_cyl_d   = out_cyl_q;
    out_sum_d   = out_sum_q;
    out_empty_d = out_empty_q;
    out_drop_d  = out_drop_q;
    out_last_d  = out_last_q;

    if (rd_valid_q && !rd_served) begin
      if (rd_val < split_q) begin
        if (!lo_found_q || (rd_val > lo_val_q)) begin
          lo_found_d = 1'b1;
          lo_val_d   = rd_val;
          lo_idx_d   = rd_idx_q;
        end
      end else begin
        if (!hi_found_q || (rd_val < hi_val_q)) begin
          hi_found_d = 1'b1;
          hi_val_d   = rd_val;
          hi_idx_d   = rd_idx_q;
        end
      end
    end

    case (state_q)
      sstf_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.action == sstf_pkg::ACT_LOAD) begin
            if (has_room) begin
              count_d = count_q + CW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end else begin
            head_d  = in_i.position;
            split_d = in_i.position;
            sum_d   = '0;
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_cyl_d   = '0;
              out_sum_d   = '0;
              out_empty_d = 1'b1;
              out_drop_d  = dropped_q;
              out_last_d  = 1'b1;
              dropped_d   = 1'b0;
            end else begin
              served_d   = '0;
              addr_d     = '0;
              lo_found_d = 1'b0;
              hi_found_d = 1'b0;
              state_d    = sstf_pkg::S_SCAN;
            end
          end
        end
      end
      sstf_pkg::S_SCAN: begin
        if (CW'(addr_q) == (count_q - CW'(1))) begin
          state_d = sstf_pkg::S_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      sstf_pkg::S_DRAIN: begin
        state_d = sstf_pkg::S_DECIDE;
      end
      sstf_pkg::S_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cyl_d   = pick_val;
          out_sum_d   = pick_sum;
          out_empty_d = 1'b0;
          out_drop_d  = dropped_q;
          out_last_d  = pick_last;
          head_d      = pick_val;
          sum_d       = pick_sum;
          served_d    = served_q + CW'(1);
          addr_d      = '0;
          lo_found_d  = 1'b0;
          hi_found_d  = 1'b0;
          if (pick_last) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = sstf_pkg::S_IDLE;
          end else begin
            state_d = sstf_pkg::S_SCAN;
          end
        end
      end
      default: begin
        state_d = sstf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sstf_pkg::S_IDLE;
      count_q     <= '0;
      served_q    <= '0;
      dropped_q   <= 1'b0;
      head_q      <= '0;
      sum_q       <= '0;
      addr_q      <= '0;
      rd_valid_q  <= 1'b0;
      lo_found_q  <= 1'b0;
      hi_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      served_q    <= served_d;
      dropped_q   <= dropped_d;
      head_q      <= head_d;
      sum_q       <= sum_d;
      addr_q      <= addr_d;
      rd_valid_q  <= rd_valid_d;
      lo_found_q  <= lo_found_d;
      hi_found_q  <= hi_found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    split_q     <= split_d;
    rd_idx_q    <= rd_idx_d;
    lo_val_q    <= lo_val_d;
    lo_idx_q    <= lo_idx_d;
    hi_val_q    <= hi_val_d;
    hi_idx_q    <= hi_idx_d;
    out_cyl_q   <= out_cyl_d;
    out_sum_q   <= out_sum_d;
    out_empty_q <= out_empty_d;
    out_drop_q  <= out_drop_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cylinder       = out_cyl_q;
  assign out_o.total_movement = out_sum_q;
  assign out_o.empty_run      = out_empty_q;
  assign out_o.dropped        = out_drop_q;
  assign out_o.last           = out_last_q;

endmodule

// ----- design/sstf_checker.sv -----
// Port-level checker for the scheduler and the bind that attaches it to the top level.
`include "assert_macros.svh"

module sstf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_cylinder_i,
  input logic [21:0] out_total_movement_i,
  input logic        out_empty_run_i,
  input logic        out_last_i
);

  // A result held back by the sink must not vanish, nor change its cylinder or last flag.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_cylinder_i) && $stable(out_last_i))

  // An empty run is always the single, final result of that run.
  `ASSERT_IMPLIES(a_empty_last, clk_i, rst_ni, out_valid_i && out_empty_run_i, out_last_i)

  // An empty run reports no cylinder and no movement.
  `ASSERT_IMPLIES(a_empty_zero, clk_i, rst_ni, out_valid_i && out_empty_run_i, (out_cylinder_i == 16'd0) && (out_total_movement_i == 22'd0))

  // While a run still has results to deliver, no new transaction is taken.
  `ASSERT_IMPLIES(a_busy_run, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind sstf_disk_scheduler_core sstf_checker u_sstf_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_cylinder_i       (out_o.cylinder),
  .out_total_movement_i (out_o.total_movement),
  .out_empty_run_i      (out_o.empty_run),
  .out_last_i           (out_o.last)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the SSTF disk scheduler core: random handshakes with a scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYL_W       = sstf_pkg::CYL_W;
  localparam int unsigned SUM_W       = sstf_pkg::SUM_W;
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ITEM_TARGET = 430;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_WAIT  = 400;
  localparam int          IDLE_PCT    = 31;

  typedef struct {
    logic             action;
    logic [CYL_W-1:0] position;
    bit               drain_first;
  } disk_cmd_t;

  typedef struct {
    logic [CYL_W-1:0] cylinder;
    logic [SUM_W-1:0] total_movement;
    logic             empty_run;
    logic             dropped;
    logic             last;
  } served_t;

  logic clk_i;
  logic rst_ni;

  sstf_in_if  req_bus ();
  sstf_out_if res_bus ();

  sstf_disk_scheduler_core #(
    .MAX_REQUESTS(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_bus),
    .out_o (res_bus)
  );

  disk_cmd_t        cmd_q[$];
  served_t          served_q[$];
  logic [CYL_W-1:0] queued_cyl[$];
  logic             overflow_flag;
  int               fail_count;
  int               cycle_count;
  int               results_seen;
  int               results_predicted;
  int               cmds_queued;
  logic             calm;

  assign calm = (cycle_count >= 1500) && (cycle_count < 3000);

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.action    = sstf_pkg::ACT_LOAD;
    req_bus.position  = '0;
    res_bus.ready     = 1'b0;
    overflow_flag     = 1'b0;
    fail_count        = 0;
    cycle_count       = 0;
    results_seen      = 0;
    results_predicted = 0;
    cmds_queued       = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CYL_W-1:0] seek_span(input logic [CYL_W-1:0] a,
                                                 input logic [CYL_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int sstf_serve(input logic act, input logic [CYL_W-1:0] pos);
    logic [CYL_W-1:0] order[DEPTH];
    logic [CYL_W-1:0] key;
    logic [CYL_W-1:0] here;
    logic [SUM_W-1:0] travel;
    logic             take_lower;
    served_t          r;
    int               n;
    int               i;
    int               j;
    int               lo;
    int               hi;
    if (act == sstf_pkg::ACT_LOAD) begin
      if (queued_cyl.size() < DEPTH) queued_cyl.push_back(pos);
      else overflow_flag = 1'b1;
      return 0;
    end
    r.empty_run = 1'b0;
    r.dropped   = overflow_flag;
    n           = queued_cyl.size();
    if (n == 0) begin
      r.cylinder       = '0;
      r.total_movement = '0;
      r.empty_run      = 1'b1;
      r.last           = 1'b1;
      served_q.push_back(r);
      overflow_flag = 1'b0;
      return 1;
    end
    for (i = 0; i < n; i++) begin
      key = queued_cyl[i];
      j   = i;
      while (j > 0 && order[j-1] > key) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    hi = 0;
    while (hi < n && order[hi] < pos) hi++;
    lo     = hi - 1;
    here   = pos;
    travel = '0;
    while (lo >= 0 || hi < n) begin
      if (lo < 0) take_lower = 1'b0;
      else if (hi >= n) take_lower = 1'b1;
      else take_lower = seek_span(here, order[lo]) < seek_span(here, order[hi]);
      if (take_lower) begin
        r.cylinder = order[lo];
        lo--;
      end else begin
        r.cylinder = order[hi];
        hi++;
      end
      travel           = travel + seek_span(here, r.cylinder);
      here             = r.cylinder;
      r.total_movement = travel;
      r.last           = (lo < 0) && (hi >= n);
      served_q.push_back(r);
    end
    queued_cyl.delete();
    overflow_flag = 1'b0;
    return n;
  endfunction

  task automatic check_field(input string what, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_cmd(input logic act, input logic [CYL_W-1:0] pos, input bit drain);
    disk_cmd_t c;
    c.action      = act;
    c.position    = pos;
    c.drain_first = drain;
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  function automatic logic [CYL_W-1:0] pick_cyl(input logic [CYL_W-1:0] center);
    int sel;
    int spot;
    sel = $urandom_range(99);
    if (sel < 30) return CYL_W'($urandom_range(65535));
    if (sel < 36) return '0;
    if (sel < 42) return '1;
    if (sel < 48) return center;
    spot = int'(center) + $urandom_range(600) - 300;
    if (spot < 0) spot = 0;
    if (spot > 65535) spot = 65535;
    return CYL_W'(spot);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    disk_cmd_t nxt;
    int        added;
    added = 0;
    if (!rst_ni) begin
      req_bus.valid    <= 1'b0;
      req_bus.action   <= sstf_pkg::ACT_LOAD;
      req_bus.position <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        added = sstf_serve(req_bus.action, req_bus.position);
      results_predicted <= results_predicted + added;
      if (!req_bus.valid || req_bus.ready) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
            (!cmd_q[0].drain_first || results_seen >= results_predicted + added)) begin
          nxt = cmd_q.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.action   <= nxt.action;
          req_bus.position <= nxt.position;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    served_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen <= results_seen + 1;
        if (served_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual cylinder %0d last %b",
                   $time, res_bus.cylinder, res_bus.last);
          fail_count++;
        end else begin
          want = served_q.pop_front();
          check_field("cylinder", SUM_W'(want.cylinder), SUM_W'(res_bus.cylinder));
          check_field("total_movement", want.total_movement, res_bus.total_movement);
          check_field("empty_run", SUM_W'(want.empty_run), SUM_W'(res_bus.empty_run));
          check_field("dropped", SUM_W'(want.dropped), SUM_W'(res_bus.dropped));
          check_field("last", SUM_W'(want.last), SUM_W'(res_bus.last));
        end
      end
      res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CYL_W-1:0] fill_set[17];
    logic [CYL_W-1:0] head;
    int               kind;
    int               n;
    int               seq;
    fill_set = '{16'hFFFF, 16'h0000, 16'd40000, 16'd40000, 16'd12, 16'hFFFE, 16'h8000,
                 16'h7FFF, 16'd1, 16'd20000, 16'd50000, 16'd7, 16'd60000, 16'd3000,
                 16'h8000, 16'd45000, 16'd99};
    queue_cmd(sstf_pkg::ACT_RUN, 16'd1234, 1'b0);
    queue_cmd(sstf_pkg::ACT_LOAD, 16'd100, 1'b0);
    queue_cmd(sstf_pkg::ACT_LOAD, 16'd300, 1'b0);
    queue_cmd(sstf_pkg::ACT_RUN, 16'd200, 1'b0);
    queue_cmd(sstf_pkg::ACT_LOAD, 16'h0000, 1'b0);
    queue_cmd(sstf_pkg::ACT_LOAD, 16'hFFFF, 1'b0);
    queue_cmd(sstf_pkg::ACT_RUN, 16'h0000, 1'b0);
    foreach (fill_set[k]) queue_cmd(sstf_pkg::ACT_LOAD, fill_set[k], 1'b0);
    queue_cmd(sstf_pkg::ACT_RUN, 16'h8000, 1'b0);
    seq = 0;
    while (cmds_queued < ITEM_TARGET) begin
      kind = $urandom_range(99);
      case ($urandom_range(9))
        0:       head = '0;
        1:       head = '1;
        default: head = CYL_W'($urandom_range(65535));
      endcase
      if (kind < 70) n = $urandom_range(1, 8);
      else if (kind < 80) n = $urandom_range(9, 16);
      else if (kind < 88) n = $urandom_range(17, 20);
      else if (kind < 94) n = 0;
      else n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++)
        queue_cmd(sstf_pkg::ACT_LOAD, pick_cyl(head), (k == 0) && (seq % 9 == 0));
      if (kind < 94) queue_cmd(sstf_pkg::ACT_RUN, head, (n == 0) && (seq % 9 == 0));
      seq++;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_q.size() != 0 || req_bus.valid) @(posedge clk_i);
    while (served_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && served_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sstf_pkg.sv
design/sstf_in_if.sv
design/sstf_out_if.sv
design/sstf_ram.sv
design/sstf_disk_scheduler_core.sv
design/sstf_checker.sv
dv/tb_top.sv
